// ===== design/srd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srd_pkg
// Shared types and codes for the slot ring deque with erase.
// ----------------------------------------------------------------------------
package srd_pkg;

    localparam int ModeW   = 3;
    localparam int StatusW = 2;

    typedef enum logic [ModeW-1:0] {
        MODE_PUT       = 3'd0,
        MODE_PUT_FIRST = 3'd1,
        MODE_POP       = 3'd2,
        MODE_PEEK      = 3'd3,
        MODE_CLEAR     = 3'd4,
        MODE_ERASE     = 3'd5
    } mode_t;

    typedef enum logic [StatusW-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_INIT,      // build ring after reset
        S_IDLE,
        S_RD,        // wait read of entry A
        S_PUT,
        S_PUTF,
        S_POP,
        S_CLR,       // sweep active marks
        S_ER_A,      // have active of target
        S_ER_ONLY,   // have active[0], the new head
        S_ER_TNX,    // have next[tail]
        S_ER_TSKIP,  // have active/next of tail candidate
        S_ER_HNX,    // have next[head] for head step
        S_ER_INX,    // have next[target]
        S_ER_NHACT,  // newest: re-check head active
        S_ER_WALK,   // walk: have next of cur
        S_ER_PV,     // have prev[target]
        S_ER_U1,     // write next[pv], prev[nx]
        S_ER_BT,     // have prev[tail]
        S_ER_L1,     // write next[bt], prev[it]
        S_ER_L2,     // write next[it], prev[tail]
        S_ER_FULL,   // have active[head]
        S_DONE
    } state_t;

endpackage : srd_pkg
`default_nettype wire

// ===== design/slot_ring_deque_with_erase_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slot_ring_deque_with_erase_unit
// Ring of slot indices with next/prev links in memories; put, put-first,
// pop, peek, clear and erase of any slot.
// ----------------------------------------------------------------------------
// channel  dir  tdata bits                        tuser
// s_       in   [2:0] mode, [6:3] target_slot     -
// m_       out  [1:0] status, [5:2] slot,         -
//                [6] full_res, [7] empty_res
//
// Erase walks the links with one memory read per step; clear sweeps
// the active marks of every slot.
// After reset the ring is built by a sweep over all slots; s_tready is low.
// One beat in flight; the result is held in an output register until taken,
// and the next beat is accepted the cycle after the result is taken.
// ----------------------------------------------------------------------------
module slot_ring_deque_with_erase_unit #(
    parameter int SLOTS = 16
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [7:0]  s_tdata,   // [2:0] mode, [6:3] target_slot
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata    // [1:0] status, [5:2] slot, [6] full, [7] empty
);
    import srd_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [AW-1:0] nxt_mem [SLOTS];
    logic [AW-1:0] prv_mem [SLOTS];
    logic          act_mem [SLOTS];

    // single read address per memory, registered data
    logic [AW-1:0] n_raddr, p_raddr, a_raddr;
    logic [AW-1:0] n_rdata, p_rdata;
    logic          a_rdata;
    logic          n_we, p_we, a_we;
    logic [AW-1:0] n_waddr, p_waddr, a_waddr, n_wdata, p_wdata;
    logic          a_wdata;

    always_ff @(posedge aclk) begin
        if (n_we) nxt_mem[n_waddr] <= n_wdata;
        if (p_we) prv_mem[p_waddr] <= p_wdata;
        if (a_we) act_mem[a_waddr] <= a_wdata;
        n_rdata <= nxt_mem[n_raddr];
        p_rdata <= prv_mem[p_raddr];
        a_rdata <= act_mem[a_raddr];
    end

    state_t        state_reg, state_next;
    logic [AW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [AW-1:0] cnt_reg, cnt_next;         // sweep index
    logic [AW:0]   steps_reg, steps_next;     // walk bound
    logic [AW-1:0] x_reg, x_next;             // cur / pv / bt
    logic [AW-1:0] y_reg, y_next;             // nx
    logic [AW-1:0] tgt_reg, tgt_next;
    logic          tgt_oor_reg, tgt_oor_next;
    mode_t         mode_reg, mode_next;
    logic          hact_reg, hact_next;       // active[head] mirror
    logic          fullflag_reg, fullflag_next;
    status_t       st_reg, st_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic          ov_reg, ov_next;
    logic [7:0]    od_reg, od_next;

    logic [3:0] tgt_in;
    assign tgt_in = s_tdata[6:3];

    assign s_tready = (state_reg == S_IDLE) && !ov_reg;
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;

    logic [AW-1:0] last_idx;
    assign last_idx = AW'(SLOTS - 1);

    always_comb begin
        logic [3:0] slot4;
        logic       fl, em;
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        cnt_next      = cnt_reg;
        steps_next    = steps_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        tgt_next      = tgt_reg;
        tgt_oor_next  = tgt_oor_reg;
        mode_next     = mode_reg;
        hact_next     = hact_reg;
        fullflag_next = fullflag_reg;
        st_next       = st_reg;
        slot_next     = slot_reg;
        ov_next       = ov_reg && !m_tready;
        od_next       = od_reg;
        n_raddr = head_reg; p_raddr = tail_reg; a_raddr = head_reg;
        n_we = 1'b0; p_we = 1'b0; a_we = 1'b0;
        n_waddr = cnt_reg; p_waddr = cnt_reg; a_waddr = cnt_reg;
        n_wdata = '0; p_wdata = '0; a_wdata = 1'b0;
        slot4 = '0; fl = 1'b0; em = 1'b0;

        case (state_reg)
            S_INIT: begin
                n_we = 1'b1; p_we = 1'b1; a_we = 1'b1;
                n_wdata = (cnt_reg == last_idx) ? '0 : cnt_reg + 1'b1;
                p_wdata = (cnt_reg == '0) ? last_idx : cnt_reg - 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == last_idx) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    mode_next    = mode_t'(s_tdata[2:0]);
                    tgt_next     = AW'(tgt_in);
                    tgt_oor_next = ({28'd0, tgt_in} >= SLOTS);
                    st_next      = ST_OK;
                    slot_next    = '0;
                    cnt_next     = '0;
                    steps_next   = '0;
                    // read entry data for head/tail
                    n_raddr = head_reg; p_raddr = tail_reg;
                    a_raddr = AW'(tgt_in);
                    state_next = S_RD;
                    case (mode_t'(s_tdata[2:0]))
                        MODE_PUT, MODE_PUT_FIRST: begin
                            if (head_reg == tail_reg && hact_reg) begin
                                st_next = ST_FULL; state_next = S_DONE;
                            end
                        end
                        MODE_POP, MODE_PEEK: begin
                            if (head_reg == tail_reg && !hact_reg) begin
                                st_next = ST_EMPTY; state_next = S_DONE;
                            end else if (s_tdata[2:0] == MODE_PEEK) begin
                                slot_next = tail_reg; state_next = S_DONE;
                            end
                        end
                        MODE_CLEAR: state_next = S_CLR;
                        MODE_ERASE: begin
                            if ({28'd0, tgt_in} >= SLOTS) begin
                                st_next = ST_NOT_FOUND; state_next = S_DONE;
                            end else begin
                                n_raddr = tail_reg; p_raddr = head_reg;
                                state_next = S_ER_A;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_RD: begin
                case (mode_reg)
                    MODE_PUT: begin
                        slot_next = head_reg;
                        a_we = 1'b1; a_waddr = head_reg; a_wdata = 1'b1;
                        head_next = n_rdata;
                        // head moves: active of new head = (new head == tail)
                        hact_next = (n_rdata == tail_reg);
                        state_next = S_DONE;
                    end
                    MODE_PUT_FIRST: begin
                        tail_next = p_rdata; slot_next = p_rdata;
                        a_we = 1'b1; a_waddr = p_rdata; a_wdata = 1'b1;
                        if (p_rdata == head_reg) hact_next = 1'b1;
                        state_next = S_DONE;
                    end
                    default: begin // pop
                        slot_next = tail_reg;
                        a_we = 1'b1; a_waddr = tail_reg; a_wdata = 1'b0;
                        n_raddr = tail_reg;
                        if (tail_reg == head_reg) hact_next = 1'b0;
                        state_next = S_POP;
                    end
                endcase
            end
            S_POP: begin
                // n_rdata = next[tail] read in IDLE (head addr) is wrong; reread
                tail_next = n_rdata;
                state_next = S_DONE;
            end
            S_CLR: begin
                a_we = 1'b1; a_waddr = cnt_reg; a_wdata = 1'b0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == last_idx) begin
                    head_next = '0; tail_next = '0; hact_next = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_ER_A: begin
                // n_rdata = next[tail], p_rdata = prev[head], a_rdata = act[tgt]
                if (!a_rdata) begin
                    st_next = ST_EMPTY; state_next = S_DONE;
                end else begin
                    a_we = 1'b1; a_waddr = tgt_reg; a_wdata = 1'b0;
                    if (tgt_reg == head_reg) hact_next = 1'b0;
                    if (tail_reg == p_rdata && tail_reg == tgt_reg) begin
                        head_next = '0; tail_next = '0;
                        n_raddr = '0; a_raddr = '0;
                        state_next = S_ER_ONLY;
                    end else if (tgt_reg == tail_reg) begin
                        tail_next = n_rdata;
                        n_raddr = n_rdata; a_raddr = n_rdata;
                        steps_next = '0;
                        state_next = S_ER_TSKIP;
                    end else begin
                        n_raddr = tgt_reg;
                        state_next = S_ER_INX;
                    end
                end
            end
            S_ER_ONLY: begin
                // head moved to slot 0; the read of slot 0 raced the clear of
                // the target when the target was slot 0
                hact_next = (tgt_reg == '0) ? 1'b0 : a_rdata;
                state_next = S_DONE;
            end
            S_ER_TSKIP: begin
                // tail_reg is candidate; a_rdata active, n_rdata next
                if (steps_reg < (AW+1)'(SLOTS) && tail_reg != head_reg && !a_rdata) begin
                    tail_next  = n_rdata;
                    steps_next = steps_reg + 1'b1;
                    n_raddr = n_rdata; a_raddr = n_rdata;
                end else if (tail_reg == head_reg && hact_reg) begin
                    n_raddr = head_reg; a_raddr = head_reg;
                    state_next = S_ER_TNX;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_ER_TNX: begin
                state_next = S_ER_HNX;
                n_raddr = head_reg;
            end
            S_ER_HNX: begin
                head_next = n_rdata;
                hact_next = (n_rdata == tail_reg);
                state_next = S_DONE;
            end
            S_ER_INX: begin
                if (n_rdata == head_reg) begin
                    head_next = tgt_reg;
                    hact_next = 1'b0; // target just cleared
                    state_next = S_DONE;
                end else begin
                    n_raddr = tail_reg;
                    state_next = S_ER_NHACT;
                end
            end
            S_ER_NHACT: begin
                // n_rdata = next[tail] -> cur
                x_next = n_rdata; steps_next = '0;
                n_raddr = n_rdata;
                fullflag_next = (head_reg == tail_reg) && hact_reg;
                state_next = S_ER_WALK;
            end
            S_ER_WALK: begin
                if (steps_reg < (AW+1)'(SLOTS) && x_reg != head_reg) begin
                    if (x_reg == tgt_reg) begin
                        p_raddr = tgt_reg; n_raddr = tgt_reg;
                        state_next = S_ER_PV;
                    end else begin
                        x_next = n_rdata; n_raddr = n_rdata;
                        steps_next = steps_reg + 1'b1;
                    end
                end else begin
                    st_next = ST_NOT_FOUND; state_next = S_DONE;
                end
            end
            S_ER_PV: begin
                x_next = p_rdata; y_next = n_rdata;
                state_next = S_ER_U1;
            end
            S_ER_U1: begin
                n_we = 1'b1; n_waddr = x_reg; n_wdata = y_reg;
                p_we = 1'b1; p_waddr = y_reg; p_wdata = x_reg;
                p_raddr = tail_reg;
                state_next = S_ER_BT;
            end
            S_ER_BT: begin
                // forward in case prev[tail] was just written
                x_next = (y_reg == tail_reg) ? x_reg : p_rdata;
                state_next = S_ER_L1;
            end
            S_ER_L1: begin
                n_we = 1'b1; n_waddr = x_reg; n_wdata = tgt_reg;
                p_we = 1'b1; p_waddr = tgt_reg; p_wdata = x_reg;
                state_next = S_ER_L2;
            end
            S_ER_L2: begin
                n_we = 1'b1; n_waddr = tgt_reg; n_wdata = tail_reg;
                p_we = 1'b1; p_waddr = tail_reg; p_wdata = tgt_reg;
                if (fullflag_reg) begin
                    head_next = tgt_reg; hact_next = 1'b0;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                fl = (head_reg == tail_reg) && hact_reg;
                em = (head_reg == tail_reg) && !hact_reg;
                slot4 = 4'(slot_reg);
                od_next = {em, fl, slot4, st_reg};
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            head_reg  <= '0;
            tail_reg  <= '0;
            cnt_reg   <= '0;
            hact_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            hact_reg  <= hact_next;
            ov_reg    <= ov_next;
        end
        steps_reg    <= steps_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        tgt_reg      <= tgt_next;
        tgt_oor_reg  <= tgt_oor_next;
        mode_reg     <= mode_next;
        fullflag_reg <= fullflag_next;
        st_reg       <= st_next;
        slot_reg     <= slot_next;
        od_reg       <= od_next;
    end

    // a pending result holds, unchanged, until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("accept while result pending");
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[6] && m_tdata[7]))
        else $error("full and empty together");
    a_oor: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ER_A |-> !tgt_oor_reg)
        else $error("erase of out of range target");

endmodule : slot_ring_deque_with_erase_unit
`default_nettype wire

// ===== tb/tb_slot_ring_deque_with_erase_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slot_ring_deque_with_erase_unit
// Self-checking bench for the slot ring deque: a directed run over every mode
// and corner case, then random op sequences, with the results compared beat
// by beat against a behavioral copy of the ring, its links and marks.
// ----------------------------------------------------------------------------
module tb_slot_ring_deque_with_erase_unit;
    import srd_pkg::*;

    localparam int SLOTS = 16;

    // first member in the highest bits: matches m_tdata layout
    typedef struct packed {
        logic       empty_res;
        logic       full_res;
        logic [3:0] slot;
        logic [1:0] status;
    } ring_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;   // [2:0] mode, [6:3] target_slot
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // [1:0] status, [5:2] slot, [6] full, [7] empty

    slot_ring_deque_with_erase_unit #(.SLOTS(SLOTS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 aclk = ~aclk;

    // shadow ring
    logic [3:0] nxt_q [SLOTS];
    logic [3:0] prv_q [SLOTS];
    logic       busy_q [SLOTS];
    logic [3:0] head_q, tail_q;

    logic [7:0]   op_queue [$];
    ring_result_t result_queue [$];
    int           errors = 0;
    bit           quiet_in = 1'b0;
    bit           quiet_out = 1'b0;
    bit           hold_go = 1'b0;
    bit           hold_used = 1'b0;
    int           hold_cycles = 0;

    function automatic bit ring_full();
        return head_q == tail_q && busy_q[head_q];
    endfunction

    function automatic bit ring_empty();
        return head_q == tail_q && !busy_q[head_q];
    endfunction

    function automatic logic [1:0] erase_slot(logic [3:0] it);
        bit         found;
        logic [3:0] cur, pv, nx, bt;
        found = 1'b0;
        if (!busy_q[it]) return ST_EMPTY;
        busy_q[it] = 1'b0;
        if (tail_q == prv_q[head_q] && tail_q == it) begin
            head_q = '0;
            tail_q = '0;
            return ST_OK;
        end
        if (it == tail_q) begin
            tail_q = nxt_q[tail_q];
            for (int n = 0; n < SLOTS && tail_q != head_q && !busy_q[tail_q]; n++)
                tail_q = nxt_q[tail_q];
            if (tail_q == head_q && busy_q[tail_q]) head_q = nxt_q[head_q];
            return ST_OK;
        end
        if (nxt_q[it] == head_q) begin
            head_q = it;
            if (tail_q == head_q && busy_q[tail_q]) head_q = nxt_q[head_q];
            return ST_OK;
        end
        cur = nxt_q[tail_q];
        for (int n = 0; n < SLOTS && cur != head_q; n++) begin
            if (cur == it) begin
                found = 1'b1;
                break;
            end
            cur = nxt_q[cur];
        end
        if (!found) return ST_NOT_FOUND;
        pv = prv_q[it];
        nx = nxt_q[it];
        nxt_q[pv] = nx;
        prv_q[nx] = pv;
        bt = prv_q[tail_q];
        nxt_q[bt] = it;
        prv_q[it] = bt;
        nxt_q[it] = tail_q;
        prv_q[tail_q] = it;
        if (head_q == tail_q && busy_q[head_q]) head_q = it;
        return ST_OK;
    endfunction

    function automatic ring_result_t apply_op(logic [7:0] beat);
        ring_result_t r;
        logic [3:0]   tgt;
        r = '0;
        tgt = beat[6:3];
        case (beat[2:0])
            MODE_PUT: begin
                if (ring_full()) r.status = ST_FULL;
                else begin
                    r.slot = head_q;
                    busy_q[head_q] = 1'b1;
                    head_q = nxt_q[head_q];
                end
            end
            MODE_PUT_FIRST: begin
                if (ring_full()) r.status = ST_FULL;
                else begin
                    tail_q = prv_q[tail_q];
                    r.slot = tail_q;
                    busy_q[tail_q] = 1'b1;
                end
            end
            MODE_POP: begin
                if (ring_empty()) r.status = ST_EMPTY;
                else begin
                    r.slot = tail_q;
                    busy_q[tail_q] = 1'b0;
                    tail_q = nxt_q[tail_q];
                end
            end
            MODE_PEEK: begin
                if (ring_empty()) r.status = ST_EMPTY;
                else r.slot = tail_q;
            end
            MODE_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) busy_q[i] = 1'b0;
                head_q = '0;
                tail_q = '0;
            end
            MODE_ERASE: r.status = erase_slot(tgt);
            default: ;
        endcase
        r.full_res = ring_full();
        r.empty_res = ring_empty();
        return r;
    endfunction

    function automatic logic [7:0] pack_op(logic [2:0] m, logic [3:0] t);
        return {1'b0, t, m};
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (op_queue.size() > 0 && (quiet_in || $urandom_range(99) >= 11)) begin
                s_tdata <= op_queue.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // prediction at acceptance
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            result_queue.push_back(apply_op(s_tdata));
    end

    // receiver readiness, with a long hold-off once
    always @(posedge aclk) begin
        if (hold_go && !hold_used) begin
            hold_used <= 1'b1;
            hold_cycles <= 300;
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet_out || ($urandom_range(99) >= 11);
        end
    end

    // monitor
    always @(posedge aclk) begin
        ring_result_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (result_queue.size() == 0) begin
                $error("result beat with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                exp_r = result_queue.pop_front();
                if (got.status != exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, got.status);
                    errors++;
                end
                if (got.slot != exp_r.slot) begin
                    $error("slot exp %0d got %0d", exp_r.slot, got.slot);
                    errors++;
                end
                if (got.full_res != exp_r.full_res) begin
                    $error("full_res exp %0d got %0d", exp_r.full_res, got.full_res);
                    errors++;
                end
                if (got.empty_res != exp_r.empty_res) begin
                    $error("empty_res exp %0d got %0d", exp_r.empty_res, got.empty_res);
                    errors++;
                end
            end
        end
    end

    initial begin
        int k;
        for (int i = 0; i < SLOTS; i++) begin
            nxt_q[i] = 4'(i + 1);
            prv_q[i] = 4'(i + SLOTS - 1);
            busy_q[i] = 1'b0;
        end
        head_q = '0;
        tail_q = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty cases, fill to full, erase corners, odd modes
        op_queue.push_back(pack_op(MODE_POP, 4'd0));
        op_queue.push_back(pack_op(MODE_PEEK, 4'd15));
        op_queue.push_back(pack_op(MODE_ERASE, 4'd3));
        op_queue.push_back(pack_op(MODE_PUT, 4'd0));
        op_queue.push_back(pack_op(MODE_ERASE, 4'd0));
        for (int i = 0; i < SLOTS; i++) op_queue.push_back(pack_op(MODE_PUT_FIRST, 4'd0));
        op_queue.push_back(pack_op(MODE_PUT, 4'd0));
        op_queue.push_back(pack_op(MODE_ERASE, 4'd7));
        op_queue.push_back(pack_op(MODE_ERASE, 4'd15));
        op_queue.push_back(pack_op(3'd6, 4'd9));
        op_queue.push_back(pack_op(3'd7, 4'd0));
        op_queue.push_back(pack_op(MODE_CLEAR, 4'd0));

        // random: mostly puts and erases of random target slots, with pops/clears
        for (int i = 0; i < 1800; i++) begin
            k = $urandom_range(99);
            if (k < 30)      op_queue.push_back(pack_op(MODE_PUT, 4'($urandom)));
            else if (k < 45) op_queue.push_back(pack_op(MODE_PUT_FIRST, 4'($urandom)));
            else if (k < 60) op_queue.push_back(pack_op(MODE_POP, 4'($urandom)));
            else if (k < 66) op_queue.push_back(pack_op(MODE_PEEK, 4'($urandom)));
            else if (k < 68) op_queue.push_back(pack_op(MODE_CLEAR, 4'($urandom)));
            else if (k < 98) op_queue.push_back(pack_op(MODE_ERASE, 4'($urandom)));
            else             op_queue.push_back(pack_op(3'($urandom_range(7, 6)), 4'($urandom)));
        end

        // long hold-off on the result side, then a calm stretch
        wait (op_queue.size() < 1200);
        @(posedge aclk);
        hold_go <= 1'b1;
        wait (op_queue.size() < 900);
        quiet_in <= 1'b1;
        quiet_out <= 1'b1;
        wait (op_queue.size() < 600);
        quiet_in <= 1'b0;
        quiet_out <= 1'b0;

        wait (op_queue.size() == 0);
        @(posedge aclk);
        while (s_tvalid || result_queue.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
